// ===== rtl/swaabb_pkg.sv =====
// ----------------------------------------------------------------------------
// swaabb_pkg
// Shared constants for the swept box contact-time core.
// ----------------------------------------------------------------------------
`default_nettype none
package swaabb_pkg;

    localparam int DEF_COORD_BITS     = 16;
    localparam int DEF_TIME_FRAC_BITS = 16;

    // divider lanes: first-contact x/y, last-contact x/y
    localparam int NUM_LANES  = 4;
    localparam int LANE_FX    = 0;
    localparam int LANE_FY    = 1;
    localparam int LANE_LX    = 2;
    localparam int LANE_LY    = 3;

endpackage
`default_nettype wire

// ===== rtl/swept_aabb_contact_times_core.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_contact_times_core
// Swept 2D box-vs-box test: hit flag plus first/last contact times in a frame.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_ready    | a_*, b_* box edges, vel_a_*, vel_b_*
//  output  | out_valid / out_ready  | hit, time_first, time_last
//
//  One pair per cycle while the output is not stalled. out_valid follows the
//  input register, the divider stages and the output register. The four
//  quotients run in restoring dividers, one quotient bit per pipeline stage.
//  Reset clears the stage valid bits only; no clearing pass.
//  A stall at the output freezes every stage together; in_ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none
module swept_aabb_contact_times_core #(
    parameter int COORD_BITS     = swaabb_pkg::DEF_COORD_BITS,
    parameter int TIME_FRAC_BITS = swaabb_pkg::DEF_TIME_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_BITS-1:0]  a_min_x,
    input  wire logic signed [COORD_BITS-1:0]  a_min_y,
    input  wire logic signed [COORD_BITS-1:0]  a_max_x,
    input  wire logic signed [COORD_BITS-1:0]  a_max_y,
    input  wire logic signed [COORD_BITS-1:0]  b_min_x,
    input  wire logic signed [COORD_BITS-1:0]  b_min_y,
    input  wire logic signed [COORD_BITS-1:0]  b_max_x,
    input  wire logic signed [COORD_BITS-1:0]  b_max_y,
    input  wire logic signed [COORD_BITS-1:0]  vel_a_x,
    input  wire logic signed [COORD_BITS-1:0]  vel_a_y,
    input  wire logic signed [COORD_BITS-1:0]  vel_b_x,
    input  wire logic signed [COORD_BITS-1:0]  vel_b_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [TIME_FRAC_BITS:0]            time_first,
    output logic [TIME_FRAC_BITS:0]            time_last
);

    localparam int DW = COORD_BITS + 1;      // gap / velocity magnitude
    localparam int RW = COORD_BITS + 2;      // partial remainder
    localparam int QW = TIME_FRAC_BITS + 1;  // time word
    localparam int NS = TIME_FRAC_BITS + 1;  // quotient bits = divider stages
    localparam int NL = swaabb_pkg::NUM_LANES;

    localparam logic [QW-1:0] T_ONE = {1'b1, {TIME_FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] T_SAT = T_ONE + QW'(1);

    logic adv;

    // ---------------- input prep ----------------
    logic signed [DW-1:0] amin [2], amax [2], bmin [2], bmax [2], vel [2];
    logic                 vneg [2], vpos [2], rej [2];
    logic                 en_in  [NL];
    logic [DW-1:0]        num_in [NL];
    logic [DW-1:0]        den_in [NL];
    logic [DW-1:0]        vmag [2];
    logic                 ovl_in;

    always_comb
    begin
        amin[0] = DW'(a_min_x); amin[1] = DW'(a_min_y);
        amax[0] = DW'(a_max_x); amax[1] = DW'(a_max_y);
        bmin[0] = DW'(b_min_x); bmin[1] = DW'(b_min_y);
        bmax[0] = DW'(b_max_x); bmax[1] = DW'(b_max_y);
        vel[0]  = DW'(vel_b_x) - DW'(vel_a_x);
        vel[1]  = DW'(vel_b_y) - DW'(vel_a_y);
        for (int i = 0; i < 2; i++)
        begin
            vneg[i] = vel[i] < 0;
            vpos[i] = vel[i] > 0;
            vmag[i] = vneg[i] ? DW'(-vel[i]) : DW'(vel[i]);
            rej[i]  = vneg[i] ? (bmax[i] < amin[i]) : (vpos[i] && (bmin[i] > amax[i]));
            en_in[swaabb_pkg::LANE_FX + i]  = vneg[i] ? (amax[i] < bmin[i])
                                                      : (vpos[i] && (bmax[i] < amin[i]));
            num_in[swaabb_pkg::LANE_FX + i] = vneg[i] ? DW'(bmin[i] - amax[i])
                                                      : DW'(amin[i] - bmax[i]);
            en_in[swaabb_pkg::LANE_LX + i]  = vneg[i] ? (bmax[i] > amin[i])
                                                      : (vpos[i] && (amax[i] > bmin[i]));
            num_in[swaabb_pkg::LANE_LX + i] = vneg[i] ? DW'(bmax[i] - amin[i])
                                                      : DW'(amax[i] - bmin[i]);
            den_in[swaabb_pkg::LANE_FX + i] = vmag[i];
            den_in[swaabb_pkg::LANE_LX + i] = vmag[i];
        end
        ovl_in = !(a_max_x < b_min_x || a_min_x > b_max_x ||
                   a_max_y < b_min_y || a_min_y > b_max_y);
    end

    // ---------------- pipeline registers ----------------
    logic          vld_reg [0:NS];
    logic          ovl_reg [0:NS];
    logic          rej_reg [0:NS];
    logic          en_reg  [0:NS][NL];
    logic          sat_reg [0:NS][NL];
    logic [RW-1:0] rem_reg [0:NS][NL];
    logic [DW-1:0] den_reg [0:NS][NL];
    logic [QW-1:0] quo_reg [0:NS][NL];

    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ovl_reg[0] <= ovl_in;
            rej_reg[0] <= rej[0] | rej[1];
            for (int l = 0; l < NL; l++)
            begin
                en_reg[0][l]  <= en_in[l];
                sat_reg[0][l] <= RW'(num_in[l]) >= {den_in[l], 1'b0};
                rem_reg[0][l] <= RW'(num_in[l]);
                den_reg[0][l] <= den_in[l];
                quo_reg[0][l] <= '0;
            end
        end
    end

    // one restoring quotient bit per stage
    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [RW-1:0] rem_next [NL];
        logic [QW-1:0] quo_next [NL];
        logic [RW-1:0] diff     [NL];
        logic          ge       [NL];

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                ge[l]       = rem_reg[s][l] >= RW'(den_reg[s][l]);
                diff[l]     = ge[l] ? rem_reg[s][l] - RW'(den_reg[s][l]) : rem_reg[s][l];
                rem_next[l] = {diff[l][RW-2:0], 1'b0};
                quo_next[l] = {quo_reg[s][l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (adv)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ovl_reg[s+1] <= ovl_reg[s];
                rej_reg[s+1] <= rej_reg[s];
                for (int l = 0; l < NL; l++)
                begin
                    en_reg[s+1][l]  <= en_reg[s][l];
                    sat_reg[s+1][l] <= sat_reg[s][l];
                    rem_reg[s+1][l] <= rem_next[l];
                    den_reg[s+1][l] <= den_reg[s][l];
                    quo_reg[s+1][l] <= quo_next[l];
                end
            end
        end
    end

    // ---------------- window combine + output register ----------------
    logic [QW-1:0] clamp [NL];
    logic [QW-1:0] tf, tl;
    logic          hit_next;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            clamp[l] = (sat_reg[NS][l] || quo_reg[NS][l] > T_SAT) ? T_SAT : quo_reg[NS][l];
        tf = '0;
        tl = T_ONE;
        for (int i = 0; i < 2; i++)
        begin
            if (en_reg[NS][swaabb_pkg::LANE_FX + i] && clamp[swaabb_pkg::LANE_FX + i] > tf)
                tf = clamp[swaabb_pkg::LANE_FX + i];
            if (en_reg[NS][swaabb_pkg::LANE_LX + i] && clamp[swaabb_pkg::LANE_LX + i] < tl)
                tl = clamp[swaabb_pkg::LANE_LX + i];
        end
        hit_next = ovl_reg[NS] || (!rej_reg[NS] && tf <= tl);
    end

    logic          out_valid_reg;
    logic          hit_reg;
    logic [QW-1:0] tf_reg, tl_reg;

    assign adv = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            tf_reg  <= (hit_next && !ovl_reg[NS]) ? tf : '0;
            tl_reg  <= (hit_next && !ovl_reg[NS]) ? tl : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign time_first = tf_reg;
    assign time_last  = tl_reg;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> time_first == '0 && time_last == '0)
        else $error("miss with nonzero times");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> time_first <= time_last && time_last <= T_ONE)
        else $error("contact window out of order");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg[NS]) && !$past(in_ready))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
